@@ hw/rtl/ppg_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppg_pkg: shared types and constants of the preamble peak packet gate
// Holds the register map, the configuration bundle, the request format
// that travels from the front end to the back end, and the state encodings.
// ----------------------------------------------------------------------------
package ppg_pkg;

    localparam int CORR_W    = 16;
    localparam int POWER_W   = 32;
    localparam int SMP_W     = 16;
    localparam int PLATEAU_W = 7;
    localparam int SPAN_W    = 12;
    localparam int PKT_W     = 32;
    localparam int KIND_W    = 2;

    // One stored hit: correlation, quadrature part, in-phase part.
    localparam int STORE_W = CORR_W + 2 * SMP_W;

    localparam int PREAMBLE_SAMPLES = 320 * 8 + 32 * 20;
    localparam int SPAN_OFFSET      = 31;

    localparam logic [CORR_W-1:0]    CORR_THR_RST  = 16'd52428;
    localparam logic [POWER_W-1:0]   POWER_THR_RST = 32'd1000;
    localparam logic [PLATEAU_W-1:0] PLATEAU_RST   = 7'd16;
    localparam logic [SPAN_W-1:0]    SPAN_RST      = SPAN_W'(PREAMBLE_SAMPLES - SPAN_OFFSET);

    localparam int APB_ADDR_W  = 4;
    localparam int APB_DATA_W  = 32;
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        REG_CORR_THR  = 2'd0,
        REG_POWER_THR = 2'd1,
        REG_PLATEAU   = 2'd2,
        REG_SPAN      = 2'd3
    } reg_idx_t;

    typedef enum logic [KIND_W-1:0] {
        KIND_SAMPLE   = 2'd0,
        KIND_PREAMBLE = 2'd1,
        KIND_END      = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        MODE_SEARCH  = 2'd0,
        MODE_COPY    = 2'd1,
        MODE_PAYLOAD = 2'd2
    } mode_t;

    typedef enum logic {
        OP_EMIT   = 1'b0,
        OP_REPLAY = 1'b1
    } cmd_op_t;

    typedef enum logic {
        BK_IDLE   = 1'b0,
        BK_STREAM = 1'b1
    } back_state_t;

    typedef struct packed {
        logic [CORR_W-1:0]    corr_thr;
        logic [POWER_W-1:0]   power_thr;
        logic [PLATEAU_W-1:0] plateau;
        logic [SPAN_W-1:0]    span;
    } cfg_t;

    typedef struct packed {
        cmd_op_t            op;
        logic [CORR_W-1:0]  corr;
        logic [SMP_W-1:0]   smp_i;
        logic [SMP_W-1:0]   smp_q;
        kind_t              kind;
        logic [PKT_W-1:0]   pkt;
    } cmd_t;

endpackage

@@ hw/rtl/ppg_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppg_ram: generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ppg_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

@@ hw/rtl/ppg_fifo.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppg_fifo: request queue between front end and back end
// A short register-based first-in first-out queue.
// ----------------------------------------------------------------------------
module ppg_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    output logic             full,
    input  logic             pop,
    output logic             pop_valid,
    output logic [WIDTH-1:0] pop_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = (count_reg == CW'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_data  = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ hw/rtl/ppg_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppg_front: input side of the packet gate
// Accepts samples, runs the search, copy and payload modes, stores plateau
// hits and issues emit or replay requests to the back end.
// ----------------------------------------------------------------------------
module ppg_front #(
    parameter int STORE_DEPTH = 64,
    parameter int IDX_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  ppg_pkg::cfg_t               cfg,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [ppg_pkg::CORR_W-1:0]  s_corr_in,
    input  logic [ppg_pkg::POWER_W-1:0] s_power_in,
    input  logic signed [ppg_pkg::SMP_W-1:0] s_in_i,
    input  logic signed [ppg_pkg::SMP_W-1:0] s_in_q,
    output logic                        push_valid,
    output ppg_pkg::cmd_t               push_cmd,
    output logic [IDX_W-1:0]            push_first,
    output logic [IDX_W-1:0]            push_last,
    input  logic                        q_full,
    output logic                        ram_we,
    output logic [IDX_W-1:0]            ram_waddr,
    output logic [ppg_pkg::STORE_W-1:0] ram_wdata,
    input  logic                        replay_done
);

    import ppg_pkg::*;

    localparam int CNT_W = $clog2(STORE_DEPTH + 1);
    localparam int EW    = (CNT_W > PLATEAU_W) ? CNT_W : PLATEAU_W;
    localparam int TW    = ((IDX_W > SPAN_W) ? IDX_W : SPAN_W) + 2;
    localparam int CC_W  = TW - 1;

    mode_t              mode_reg, mode_next;
    logic [CNT_W-1:0]   hit_count_reg, hit_count_next;
    logic               relaxed_reg, relaxed_next;
    logic [IDX_W-1:0]   peak_index_reg, peak_index_next;
    logic [CORR_W-1:0]  peak_value_reg, peak_value_next;
    logic [CC_W-1:0]    copy_count_reg, copy_count_next;
    logic [PKT_W-1:0]   packet_count_reg, packet_count_next;
    logic               busy_reg, busy_next;

    logic               accept;
    logic [CORR_W-1:0]  thr;
    logic               pwr_ok;
    logic               is_hit;
    logic               new_peak;
    logic [IDX_W-1:0]   peak_sel;
    logic [CNT_W-1:0]   hit_inc;
    logic [EW-1:0]      eff_plateau;
    logic               plateau_full;
    logic [TW-1:0]      tgt_search;
    logic [TW-1:0]      tgt_copy;
    logic [CC_W-1:0]    cc_inc;

    // Input stalls while a replay is outstanding, since the next search
    // would overwrite the store that the back end is still reading.
    assign s_ready   = !busy_reg && !q_full;
    assign accept    = s_valid && s_ready;
    assign ram_waddr = hit_count_reg[IDX_W-1:0];
    assign ram_wdata = {s_corr_in, s_in_q, s_in_i};

    always_comb begin
        if (cfg.plateau == '0) begin
            eff_plateau = EW'(1);
        end else if (EW'(cfg.plateau) > EW'(STORE_DEPTH)) begin
            eff_plateau = EW'(STORE_DEPTH);
        end else begin
            eff_plateau = EW'(cfg.plateau);
        end
    end

    always_comb begin
        thr          = relaxed_reg ? '0 : cfg.corr_thr;
        pwr_ok       = (s_power_in > cfg.power_thr);
        is_hit       = (s_corr_in > thr) && pwr_ok;
        new_peak     = (s_corr_in > peak_value_reg);
        peak_sel     = new_peak ? hit_count_reg[IDX_W-1:0] : peak_index_reg;
        hit_inc      = hit_count_reg + 1'b1;
        plateau_full = (EW'(hit_inc) >= eff_plateau);
        tgt_search   = TW'(cfg.span) + TW'(peak_sel) + TW'(1) - TW'(hit_inc);
        tgt_copy     = TW'(cfg.span) + TW'(peak_index_reg) + TW'(1) - TW'(hit_count_reg);
        cc_inc       = copy_count_reg + 1'b1;
    end

    always_comb begin
        mode_next         = mode_reg;
        hit_count_next    = hit_count_reg;
        relaxed_next      = relaxed_reg;
        peak_index_next   = peak_index_reg;
        peak_value_next   = peak_value_reg;
        copy_count_next   = copy_count_reg;
        packet_count_next = packet_count_reg;
        busy_next         = busy_reg;
        push_valid        = 1'b0;
        push_cmd          = '{op: OP_EMIT, corr: s_corr_in, smp_i: s_in_i, smp_q: s_in_q,
                              kind: KIND_SAMPLE, pkt: '0};
        push_first        = peak_sel;
        push_last         = hit_count_reg[IDX_W-1:0];
        ram_we            = 1'b0;

        if (busy_reg && replay_done) begin
            busy_next = 1'b0;
        end

        if (accept) begin
            unique case (mode_reg)
                MODE_SEARCH: begin
                    if (is_hit) begin
                        ram_we         = 1'b1;
                        relaxed_next   = 1'b1;
                        hit_count_next = hit_inc;
                        if (new_peak) begin
                            peak_value_next = s_corr_in;
                            peak_index_next = peak_sel;
                        end
                        if (plateau_full) begin
                            packet_count_next = packet_count_reg + 1'b1;
                            push_valid        = 1'b1;
                            push_cmd.op       = OP_REPLAY;
                            busy_next         = 1'b1;
                            relaxed_next      = 1'b0;
                            copy_count_next   = '0;
                            // A non-positive copy length skips straight to payload.
                            if (tgt_search[TW-1] || tgt_search == '0) begin
                                mode_next      = MODE_PAYLOAD;
                                hit_count_next = '0;
                            end else begin
                                mode_next = MODE_COPY;
                            end
                        end
                    end
                end
                MODE_COPY: begin
                    push_valid      = 1'b1;
                    copy_count_next = cc_inc;
                    if ($signed({1'b0, cc_inc}) >= $signed(tgt_copy)) begin
                        mode_next       = MODE_PAYLOAD;
                        copy_count_next = '0;
                        hit_count_next  = '0;
                    end
                end
                MODE_PAYLOAD: begin
                    push_valid    = 1'b1;
                    push_cmd.corr = '0;
                    if (!pwr_ok) begin
                        push_cmd.smp_i  = '0;
                        push_cmd.smp_q  = '0;
                        push_cmd.kind   = KIND_END;
                        push_cmd.pkt    = packet_count_reg;
                        mode_next       = MODE_SEARCH;
                        hit_count_next  = '0;
                        relaxed_next    = 1'b0;
                        peak_index_next = '0;
                        peak_value_next = '0;
                        copy_count_next = '0;
                    end
                end
                default: begin
                    mode_next = MODE_SEARCH;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg         <= MODE_SEARCH;
            hit_count_reg    <= '0;
            relaxed_reg      <= 1'b0;
            peak_index_reg   <= '0;
            peak_value_reg   <= '0;
            copy_count_reg   <= '0;
            packet_count_reg <= '0;
            busy_reg         <= 1'b0;
        end else begin
            mode_reg         <= mode_next;
            hit_count_reg    <= hit_count_next;
            relaxed_reg      <= relaxed_next;
            peak_index_reg   <= peak_index_next;
            peak_value_reg   <= peak_value_next;
            copy_count_reg   <= copy_count_next;
            packet_count_reg <= packet_count_next;
            busy_reg         <= busy_next;
        end
    end

endmodule

@@ hw/rtl/ppg_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ppg_back: output side of the packet gate
// Takes requests from the queue, passes emit requests to the output
// register and streams stored hits out of the RAM for a replay request.
// ----------------------------------------------------------------------------
module ppg_back #(
    parameter int STORE_DEPTH = 64,
    parameter int IDX_W       = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        q_valid,
    input  ppg_pkg::cmd_t               q_cmd,
    input  logic [IDX_W-1:0]            q_first,
    input  logic [IDX_W-1:0]            q_last,
    output logic                        q_pop,
    output logic                        ram_re,
    output logic [IDX_W-1:0]            ram_raddr,
    input  logic [ppg_pkg::STORE_W-1:0] ram_rdata,
    output logic                        replay_done,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [ppg_pkg::CORR_W-1:0]  m_corr_out,
    output logic signed [ppg_pkg::SMP_W-1:0] m_out_i,
    output logic signed [ppg_pkg::SMP_W-1:0] m_out_q,
    output logic [ppg_pkg::KIND_W-1:0]  m_kind,
    output logic [ppg_pkg::PKT_W-1:0]   m_packet_number,
    output logic                        m_last
);

    import ppg_pkg::*;

    back_state_t        state_reg, state_next;
    logic [IDX_W-1:0]   ptr_reg, ptr_next;
    logic [IDX_W-1:0]   end_reg, end_next;
    logic               first_reg, first_next;
    logic               m_valid_reg, m_valid_next;

    logic [CORR_W-1:0]  corr_reg, corr_next;
    logic [SMP_W-1:0]   i_reg, i_next;
    logic [SMP_W-1:0]   q_reg, q_next;
    kind_t              kind_reg, kind_next;
    logic [PKT_W-1:0]   pkt_reg, pkt_next;
    logic               last_reg, last_next;

    logic               out_free;
    logic               load;

    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        state_next   = state_reg;
        ptr_next     = ptr_reg;
        end_next     = end_reg;
        first_next   = first_reg;
        m_valid_next = m_valid_reg && !m_ready;
        load         = 1'b0;
        corr_next    = corr_reg;
        i_next       = i_reg;
        q_next       = q_reg;
        kind_next    = kind_reg;
        pkt_next     = pkt_reg;
        last_next    = last_reg;
        q_pop        = 1'b0;
        ram_re       = 1'b0;
        ram_raddr    = ptr_reg + 1'b1;
        replay_done  = 1'b0;

        unique case (state_reg)
            BK_IDLE: begin
                if (q_valid) begin
                    if (q_cmd.op == OP_REPLAY) begin
                        q_pop      = 1'b1;
                        ram_re     = 1'b1;
                        ram_raddr  = q_first;
                        ptr_next   = q_first;
                        end_next   = q_last;
                        first_next = 1'b1;
                        state_next = BK_STREAM;
                    end else if (out_free) begin
                        q_pop     = 1'b1;
                        load      = 1'b1;
                        corr_next = q_cmd.corr;
                        i_next    = q_cmd.smp_i;
                        q_next    = q_cmd.smp_q;
                        kind_next = q_cmd.kind;
                        pkt_next  = q_cmd.pkt;
                        last_next = 1'b1;
                    end
                end
            end
            BK_STREAM: begin
                // The read data register holds its entry until the output frees up.
                if (out_free) begin
                    load       = 1'b1;
                    corr_next  = ram_rdata[STORE_W-1 -: CORR_W];
                    q_next     = ram_rdata[2*SMP_W-1 -: SMP_W];
                    i_next     = ram_rdata[SMP_W-1:0];
                    kind_next  = first_reg ? KIND_PREAMBLE : KIND_SAMPLE;
                    pkt_next   = '0;
                    last_next  = (ptr_reg == end_reg);
                    first_next = 1'b0;
                    if (ptr_reg == end_reg) begin
                        replay_done = 1'b1;
                        state_next  = BK_IDLE;
                    end else begin
                        ptr_next = ptr_reg + 1'b1;
                        ram_re   = 1'b1;
                    end
                end
            end
        endcase

        if (load) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            first_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            first_reg   <= first_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ptr_reg  <= ptr_next;
        end_reg  <= end_next;
        corr_reg <= corr_next;
        i_reg    <= i_next;
        q_reg    <= q_next;
        kind_reg <= kind_next;
        pkt_reg  <= pkt_next;
        last_reg <= last_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_corr_out      = corr_reg;
    assign m_out_i         = i_reg;
    assign m_out_q         = q_reg;
    assign m_kind          = kind_reg;
    assign m_packet_number = pkt_reg;
    assign m_last          = last_reg;

endmodule

@@ hw/rtl/preamble_peak_packet_gate_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// preamble_peak_packet_gate_top: packet gate for a baseband receiver
// Finds the correlation peak of a preamble plateau, replays the stored
// samples from the peak, copies the rest of the preamble and gates payload.
// ----------------------------------------------------------------------------
// Usage:
// Samples enter on the s_ channel (correlation, power, I and Q) and results
// leave on the m_ channel, both with valid/ready handshakes. Each input
// request causes zero or more results; m_last marks the final one of a
// request. The APB port sets thresholds, plateau length and preamble span
// and should only be written while no request is in flight.
// A sample that produces one result passes through the request queue and the
// output register to the m_ channel; one sample per cycle is sustained while
// the queue has room and no replay is outstanding. When a plateau completes,
// the front end queues a replay and stops accepting input until the back end
// has streamed all stored hits from the peak on: the request passes the queue,
// the first hit is read from the RAM, then results follow at one per cycle
// while the receiver is ready. A four-entry request queue separates the front
// end from the output register, so a stalled receiver first fills the queue
// and then holds s_ready low. Synchronous reset returns to search with the
// register defaults; the hit store needs no clearing.
// ----------------------------------------------------------------------------
module preamble_peak_packet_gate_top #(
    parameter int STORE_DEPTH = 64
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [ppg_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [ppg_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [ppg_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [ppg_pkg::CORR_W-1:0]        s_corr_in,
    input  logic [ppg_pkg::POWER_W-1:0]       s_power_in,
    input  logic signed [ppg_pkg::SMP_W-1:0]  s_in_i,
    input  logic signed [ppg_pkg::SMP_W-1:0]  s_in_q,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [ppg_pkg::CORR_W-1:0]        m_corr_out,
    output logic signed [ppg_pkg::SMP_W-1:0]  m_out_i,
    output logic signed [ppg_pkg::SMP_W-1:0]  m_out_q,
    output logic [ppg_pkg::KIND_W-1:0]        m_kind,
    output logic [ppg_pkg::PKT_W-1:0]         m_packet_number,
    output logic                              m_last
);

    import ppg_pkg::*;

    localparam int IDX_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int Q_W   = $bits(cmd_t) + 2 * IDX_W;

    logic [CORR_W-1:0]    corr_thr_reg;
    logic [POWER_W-1:0]   power_thr_reg;
    logic [PLATEAU_W-1:0] plateau_reg;
    logic [SPAN_W-1:0]    span_reg;
    cfg_t                 cfg;
    reg_idx_t             reg_idx;
    logic                 cfg_wr;

    logic                 push_valid;
    cmd_t                 push_cmd;
    logic [IDX_W-1:0]     push_first;
    logic [IDX_W-1:0]     push_last;
    logic                 q_full;
    logic                 q_valid;
    logic                 q_pop;
    logic [Q_W-1:0]       q_data;
    cmd_t                 q_cmd;
    logic [IDX_W-1:0]     q_first;
    logic [IDX_W-1:0]     q_last;

    logic                 ram_we;
    logic [IDX_W-1:0]     ram_waddr;
    logic [STORE_W-1:0]   ram_wdata;
    logic                 ram_re;
    logic [IDX_W-1:0]     ram_raddr;
    logic [STORE_W-1:0]   ram_rdata;
    logic                 replay_done;

    // Register file
    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[APB_ADDR_W-1:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            corr_thr_reg  <= CORR_THR_RST;
            power_thr_reg <= POWER_THR_RST;
            plateau_reg   <= PLATEAU_RST;
            span_reg      <= SPAN_RST;
        end else if (cfg_wr) begin
            unique case (reg_idx)
                REG_CORR_THR:  corr_thr_reg  <= pwdata[CORR_W-1:0];
                REG_POWER_THR: power_thr_reg <= pwdata[POWER_W-1:0];
                REG_PLATEAU:   plateau_reg   <= pwdata[PLATEAU_W-1:0];
                REG_SPAN:      span_reg      <= pwdata[SPAN_W-1:0];
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_CORR_THR:  prdata = APB_DATA_W'(corr_thr_reg);
            REG_POWER_THR: prdata = APB_DATA_W'(power_thr_reg);
            REG_PLATEAU:   prdata = APB_DATA_W'(plateau_reg);
            REG_SPAN:      prdata = APB_DATA_W'(span_reg);
        endcase
    end

    assign cfg = '{corr_thr: corr_thr_reg, power_thr: power_thr_reg,
                   plateau: plateau_reg, span: span_reg};

    ppg_front #(
        .STORE_DEPTH (STORE_DEPTH),
        .IDX_W       (IDX_W)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg         (cfg),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_corr_in   (s_corr_in),
        .s_power_in  (s_power_in),
        .s_in_i      (s_in_i),
        .s_in_q      (s_in_q),
        .push_valid  (push_valid),
        .push_cmd    (push_cmd),
        .push_first  (push_first),
        .push_last   (push_last),
        .q_full      (q_full),
        .ram_we      (ram_we),
        .ram_waddr   (ram_waddr),
        .ram_wdata   (ram_wdata),
        .replay_done (replay_done)
    );

    ppg_fifo #(
        .WIDTH (Q_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push_valid),
        .push_data ({push_cmd, push_first, push_last}),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_data  (q_data)
    );

    assign q_cmd   = cmd_t'(q_data[Q_W-1 -: $bits(cmd_t)]);
    assign q_first = q_data[2*IDX_W-1 -: IDX_W];
    assign q_last  = q_data[IDX_W-1:0];

    ppg_ram #(
        .WIDTH (STORE_W),
        .DEPTH (STORE_DEPTH),
        .AW    (IDX_W)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    ppg_back #(
        .STORE_DEPTH (STORE_DEPTH),
        .IDX_W       (IDX_W)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .q_valid         (q_valid),
        .q_cmd           (q_cmd),
        .q_first         (q_first),
        .q_last          (q_last),
        .q_pop           (q_pop),
        .ram_re          (ram_re),
        .ram_raddr       (ram_raddr),
        .ram_rdata       (ram_rdata),
        .replay_done     (replay_done),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_corr_out      (m_corr_out),
        .m_out_i         (m_out_i),
        .m_out_q         (m_out_q),
        .m_kind          (m_kind),
        .m_packet_number (m_packet_number),
        .m_last          (m_last)
    );

endmodule
